FILE: rtl/spr_pkg.sv
// shared types and constants for the servo position ramp
`default_nettype none

package spr_pkg;

   localparam int STATE_BITS     = 16;
   localparam int ANGLE_BITS     = 8;
   localparam int NORM_BITS      = 7;
   localparam int CMD_BITS       = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int PROD_BITS      = NORM_BITS + ANGLE_BITS;
   localparam int DEG_BITS       = PROD_BITS + 3;

   localparam logic [STATE_BITS-1:0] STATE_MAX     = '1;
   localparam logic [STATE_BITS-1:0] RESET_STEP    = 16'd256;
   localparam logic [ANGLE_BITS-1:0] RESET_OPEN    = 8'd0;
   localparam logic [ANGLE_BITS-1:0] RESET_CLOSED  = 8'd180;
   localparam logic                  RESET_MOUNT   = 1'b1;
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX     = '1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_TICK         = 3'd0,
      CMD_SET_MOVEMENT = 3'd1,
      CMD_STOP         = 3'd2,
      CMD_REFRESH      = 3'd3,
      CMD_OPEN         = 3'd4,
      CMD_CLOSE        = 3'd5,
      CMD_INIT         = 3'd6
   } cmd_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MAX_OPEN        = 2'd0,
      CSR_MAX_CLOSED      = 2'd1,
      CSR_MOUNT_DIRECTION = 2'd2,
      CSR_BASE_STEP       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ANGLE_BITS-1:0] max_open;
      logic [ANGLE_BITS-1:0] max_closed;
      logic                  mount_direction;
      logic [STATE_BITS-1:0] base_step;
   } config_type;

   typedef struct packed {
      cmd_type               cmd;
      logic [STATE_BITS-1:0] goal;
      logic [STATE_BITS-1:0] step;
      logic [STATE_BITS-1:0] delay;
   } work_type;

endpackage

`default_nettype wire

FILE: rtl/spr_if.sv
// channel interfaces for commands, results and register writes
`default_nettype none

interface spr_req_if;
   import spr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CMD_BITS-1:0]   cmd;
   logic [NORM_BITS-1:0]  normalized_target;
   logic [STATE_BITS-1:0] step_size;
   logic [STATE_BITS-1:0] delay_ticks;
   modport source (output valid, cmd, normalized_target, step_size, delay_ticks,
                   input ready);
   modport sink (input valid, cmd, normalized_target, step_size, delay_ticks,
                 output ready);
endinterface

interface spr_rsp_if;
   import spr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ANGLE_BITS-1:0] servo_angle;
   logic                  moved;
   logic                  still;
   modport source (output valid, servo_angle, moved, still, input ready);
   modport sink (input valid, servo_angle, moved, still, output ready);
endinterface

interface spr_csr_if;
   import spr_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/spr_front.sv
// front end: accepts commands, tracks the normalized position and maps goals
`default_nettype none

module spr_front #(
   parameter int FRAC_BITS  = 8,
   parameter int FULL_SCALE = 100
) (
   input  logic               clock,
   input  logic               reset,
   spr_req_if.sink            req,
   input  spr_pkg::config_type cfg,
   output logic               push_valid,
   output spr_pkg::work_type  push_data,
   input  logic               push_ready
);
   import spr_pkg::*;

   localparam int     RECIP_SHIFT = PROD_BITS + $clog2(FULL_SCALE);
   localparam int     RECIP_BITS  = RECIP_SHIFT + 1;
   localparam longint RECIP       =
      ((longint'(1) << RECIP_SHIFT) + longint'(FULL_SCALE) - 1) / longint'(FULL_SCALE);
   localparam logic [RECIP_BITS-1:0] RECIP_CONST = RECIP_BITS'(RECIP);
   localparam int     WIDE_BITS   = PROD_BITS + RECIP_BITS;

   function automatic logic [STATE_BITS-1:0] to_fixed(input logic [ANGLE_BITS-1:0] deg);
      logic [31:0] wide;
      wide = 32'(deg) << FRAC_BITS;
      return (|wide[31:STATE_BITS]) ? STATE_MAX : wide[STATE_BITS-1:0];
   endfunction

   logic                  advance;
   logic                  take;
   cmd_type               req_cmd;

   logic [NORM_BITS-1:0]  norm_ff, norm_in;
   logic [NORM_BITS-1:0]  norm_sel;
   logic signed [ANGLE_BITS:0] span;
   logic [ANGLE_BITS:0]   span_abs;
   logic [PROD_BITS-1:0]  prod;

   logic                  s1_valid_ff, s1_valid_in;
   cmd_type               s1_cmd_ff;
   logic [STATE_BITS-1:0] s1_step_ff, s1_step_in;
   logic [STATE_BITS-1:0] s1_delay_ff, s1_delay_in;
   logic                  s1_neg_ff;
   logic [PROD_BITS-1:0]  s1_prod_ff;

   logic [WIDE_BITS-1:0]  recip_prod;
   logic                  s2_valid_ff, s2_valid_in;
   cmd_type               s2_cmd_ff;
   logic [STATE_BITS-1:0] s2_step_ff;
   logic [STATE_BITS-1:0] s2_delay_ff;
   logic                  s2_neg_ff;
   logic [PROD_BITS-1:0]  s2_quot_ff;

   logic signed [DEG_BITS-1:0] delta;
   logic signed [DEG_BITS-1:0] deg;
   logic [ANGLE_BITS-1:0] deg_clamped;
   logic [STATE_BITS-1:0] goal_sel;

   assign advance   = push_ready;
   assign req.ready = advance;
   assign take      = req.valid && advance;
   assign req_cmd   = cmd_type'(req.cmd);

   // stage one: operand select and span product
   always_comb begin
      norm_in = norm_ff;
      if (take && req_cmd == CMD_SET_MOVEMENT) begin
         norm_in = req.normalized_target;
      end else if (take && req_cmd == CMD_INIT) begin
         norm_in = '0;
      end
      norm_sel = (req_cmd == CMD_SET_MOVEMENT) ? req.normalized_target : norm_ff;
      span     = $signed({1'b0, cfg.max_closed}) - $signed({1'b0, cfg.max_open});
      span_abs = span[ANGLE_BITS] ? (ANGLE_BITS+1)'(0) - span : span;
      prod     = PROD_BITS'(norm_sel) * PROD_BITS'(span_abs[ANGLE_BITS-1:0]);
      s1_step_in  = (req_cmd == CMD_SET_MOVEMENT) ? req.step_size : cfg.base_step;
      s1_delay_in = (req_cmd == CMD_SET_MOVEMENT) ? req.delay_ticks : '0;
      s1_valid_in = advance ? req.valid : s1_valid_ff;
   end

   // stage two: divide by full scale through the reciprocal
   assign recip_prod  = WIDE_BITS'(s1_prod_ff) * WIDE_BITS'(RECIP_CONST);
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   // final step: signed offset, clamp and fixed point goal
   always_comb begin
      delta = $signed(DEG_BITS'(s2_quot_ff));
      if (s2_neg_ff) begin
         delta = -delta;
      end
      deg = $signed(DEG_BITS'(cfg.max_open)) + delta;
      if (deg < 0) begin
         deg_clamped = '0;
      end else if (deg > $signed(DEG_BITS'(ANGLE_MAX))) begin
         deg_clamped = ANGLE_MAX;
      end else begin
         deg_clamped = deg[ANGLE_BITS-1:0];
      end
      unique case (s2_cmd_ff) inside
         CMD_SET_MOVEMENT, CMD_REFRESH: goal_sel = to_fixed(deg_clamped);
         CMD_OPEN:                      goal_sel = to_fixed(cfg.max_open);
         CMD_CLOSE:                     goal_sel = to_fixed(cfg.max_closed);
         CMD_INIT: begin
            goal_sel = to_fixed(cfg.mount_direction ? cfg.max_open : cfg.max_closed);
         end
         default:                       goal_sel = '0;
      endcase
   end

   assign push_valid     = s2_valid_ff;
   assign push_data.cmd   = s2_cmd_ff;
   assign push_data.goal  = goal_sel;
   assign push_data.step  = s2_step_ff;
   assign push_data.delay = s2_delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         norm_ff     <= norm_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff   <= req_cmd;
         s1_step_ff  <= s1_step_in;
         s1_delay_ff <= s1_delay_in;
         s1_neg_ff   <= span[ANGLE_BITS];
         s1_prod_ff  <= prod;
         s2_cmd_ff   <= s1_cmd_ff;
         s2_step_ff  <= s1_step_ff;
         s2_delay_ff <= s1_delay_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_quot_ff  <= recip_prod[RECIP_SHIFT +: PROD_BITS];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/spr_queue.sv
// short queue of classified commands between front and back
`default_nettype none

module spr_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  spr_pkg::work_type push_data,
   output logic              push_ready,
   output logic              pop_valid,
   output spr_pkg::work_type pop_data,
   input  logic              pop_ready
);
   import spr_pkg::*;

   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   LAST_PTR  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] FULL_CNT  = COUNT_BITS'(DEPTH);

   work_type                entry_ff [DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/spr_back.sv
// back end: position ramp state, tick update and result register
`default_nettype none

module spr_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   input  spr_pkg::work_type pop_data,
   output logic              pop_ready,
   spr_rsp_if.source         rsp
);
   import spr_pkg::*;

   logic                  take;
   logic [STATE_BITS-1:0] position_ff, position_in;
   logic [STATE_BITS-1:0] goal_ff, goal_in;
   logic [STATE_BITS-1:0] step_ff, step_in;
   logic [STATE_BITS-1:0] wait_ff, wait_in;
   logic [STATE_BITS-1:0] elapsed_ff, elapsed_in;

   logic [STATE_BITS:0]   sum_up;
   logic [STATE_BITS:0]   goal_plus;
   logic [STATE_BITS-1:0] gap;
   logic [31:0]           angle_wide;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_BITS-1:0] rsp_angle_ff, rsp_angle_in;
   logic                  rsp_moved_ff, rsp_moved_in;
   logic                  rsp_still_ff, rsp_still_in;

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign take      = pop_valid && pop_ready;

   always_comb begin
      position_in = position_ff;
      goal_in     = goal_ff;
      step_in     = step_ff;
      wait_in     = wait_ff;
      elapsed_in  = elapsed_ff;
      sum_up      = {1'b0, position_ff} + {1'b0, step_ff};
      goal_plus   = {1'b0, goal_ff} + {1'b0, step_ff};
      unique case (pop_data.cmd) inside
         CMD_TICK: begin
            if (elapsed_ff >= wait_ff) begin
               if (sum_up <= {1'b0, goal_ff}) begin
                  position_in = sum_up[STATE_BITS-1:0];
               end else if ({1'b0, position_ff} >= goal_plus) begin
                  position_in = position_ff - step_ff;
               end
            end
            if (elapsed_ff != STATE_MAX) begin
               elapsed_in = elapsed_ff + 1'b1;
            end
         end
         CMD_SET_MOVEMENT: begin
            goal_in    = pop_data.goal;
            step_in    = pop_data.step;
            wait_in    = pop_data.delay;
            elapsed_in = '0;
         end
         CMD_STOP: goal_in = position_ff;
         CMD_REFRESH: begin
            goal_in    = pop_data.goal;
            step_in    = pop_data.step;
            wait_in    = '0;
            elapsed_in = STATE_MAX;
         end
         CMD_OPEN, CMD_CLOSE: goal_in = pop_data.goal;
         CMD_INIT: begin
            position_in = pop_data.goal;
            goal_in     = pop_data.goal;
            step_in     = pop_data.step;
            wait_in     = '0;
            elapsed_in  = STATE_MAX;
         end
         default: ;
      endcase

      gap        = (position_in >= goal_in) ? position_in - goal_in : goal_in - position_in;
      angle_wide = 32'(position_in) >> FRAC_BITS;
      rsp_angle_in = (|angle_wide[31:ANGLE_BITS]) ? ANGLE_MAX : angle_wide[ANGLE_BITS-1:0];
      rsp_moved_in = (pop_data.cmd == CMD_TICK) && (position_in != position_ff);
      rsp_still_in = (gap <= step_in);
      rsp_valid_in = take || (rsp_valid_ff && !rsp.ready);
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.servo_angle = rsp_angle_ff;
   assign rsp.moved       = rsp_moved_ff;
   assign rsp.still       = rsp_still_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         goal_ff      <= '0;
         step_ff      <= RESET_STEP;
         wait_ff      <= '0;
         elapsed_ff   <= STATE_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            position_ff <= position_in;
            goal_ff     <= goal_in;
            step_ff     <= step_in;
            wait_ff     <= wait_in;
            elapsed_ff  <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_angle_ff <= rsp_angle_in;
         rsp_moved_ff <= rsp_moved_in;
         rsp_still_ff <= rsp_still_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/servo_position_ramp.sv
// top level of the servo position ramp: registers, front, queue and back
// a command passes both front stages, the queue and the back-end result register
// throughput: one command per cycle when the result channel does not stall the back end
// the goal mapping runs through a two-stage multiply pipeline in the front end
// reset clears position, goal and wait to zero, step to 256, elapsed to its maximum
// and the registers to open 0, closed 180, normal mount and step 256
`default_nettype none

module servo_position_ramp #(
   parameter int FRAC_BITS   = 8,
   parameter int FULL_SCALE  = 100,
   parameter int QUEUE_DEPTH = 2
) (
   input logic       clock,
   input logic       reset,
   spr_req_if.sink   req_ch,
   spr_rsp_if.source rsp_ch,
   spr_csr_if.sink   csr_ch
);
   import spr_pkg::*;

   config_type cfg_ff, cfg_in;
   logic       front_valid;
   work_type   front_data;
   logic       front_ready;
   logic       back_valid;
   work_type   back_data;
   logic       back_ready;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_MAX_OPEN:        cfg_in.max_open        = csr_ch.data[ANGLE_BITS-1:0];
            CSR_MAX_CLOSED:      cfg_in.max_closed      = csr_ch.data[ANGLE_BITS-1:0];
            CSR_MOUNT_DIRECTION: cfg_in.mount_direction = csr_ch.data[0];
            CSR_BASE_STEP:       cfg_in.base_step       = csr_ch.data[STATE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_open        <= RESET_OPEN;
         cfg_ff.max_closed      <= RESET_CLOSED;
         cfg_ff.mount_direction <= RESET_MOUNT;
         cfg_ff.base_step       <= RESET_STEP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spr_front #(
      .FRAC_BITS  (FRAC_BITS),
      .FULL_SCALE (FULL_SCALE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .cfg        (cfg_ff),
      .push_valid (front_valid),
      .push_data  (front_data),
      .push_ready (front_ready)
   );

   spr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_data),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_data),
      .pop_ready  (back_ready)
   );

   spr_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (back_valid),
      .pop_data  (back_data),
      .pop_ready (back_ready),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire
